/* rtl/lpn_pkg.sv */
// Shared types and constants for the length-prefixed to start-code converter.
`timescale 1ns / 1ps

package lpn_pkg;

  localparam int IN_W       = 8;
  localparam int LEN_BYTES  = 4;
  localparam int LEN_W      = 32;
  localparam int ACC_W      = LEN_W - IN_W;
  localparam int OUT_DATA_W = 16;

  localparam logic [7:0] SC_ZERO = 8'h00;
  localparam logic [7:0] SC_ONE  = 8'h01;

  localparam logic [1:0] SEEN_LAST = 2'(LEN_BYTES - 1);
  localparam logic [1:0] SC_LAST   = 2'(LEN_BYTES - 1);

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_IN_LEN  = 2'd1,
    ST_IN_PAYL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    JOB_BYTE   = 2'd0,
    JOB_START  = 2'd1,
    JOB_STATUS = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] data;
    logic       done;
    status_t    status;
  } job_t;

endpackage

/* rtl/lpn_parse.sv */
// Length collection and payload counting for each accepted input item.
`timescale 1ns / 1ps

module lpn_parse (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    in_byte,
  input  logic          packet_last,
  output logic          job_valid,
  output lpn_pkg::job_t job
);
  import lpn_pkg::*;

  logic             in_payload;
  logic [1:0]       length_bytes_seen;
  logic [ACC_W-1:0] length_accumulator;
  logic [LEN_W-1:0] payload_remaining;

  logic             in_payload_next;
  logic [1:0]       length_bytes_seen_next;
  logic [ACC_W-1:0] length_accumulator_next;
  logic [LEN_W-1:0] payload_remaining_next;

  logic [LEN_W-1:0] len_full;
  logic [LEN_W-1:0] rem_dec;

  assign len_full = {length_accumulator, in_byte};
  assign rem_dec  = payload_remaining - LEN_W'(1);

  always_comb begin
    in_payload_next         = in_payload;
    length_bytes_seen_next  = length_bytes_seen;
    length_accumulator_next = length_accumulator;
    payload_remaining_next  = payload_remaining;
    job_valid               = 1'b0;
    job.kind                = JOB_BYTE;
    job.data                = in_byte;
    job.done                = packet_last;
    job.status              = ST_OK;
    if (!in_payload) begin
      if (length_bytes_seen == SEEN_LAST) begin
        job_valid               = 1'b1;
        job.kind                = JOB_START;
        length_bytes_seen_next  = '0;
        length_accumulator_next = '0;
        if (packet_last && len_full != '0) begin
          job.status = ST_IN_PAYL;
        end
        if (len_full != '0) begin
          in_payload_next        = 1'b1;
          payload_remaining_next = len_full;
        end
      end else begin
        length_bytes_seen_next  = length_bytes_seen + 2'd1;
        length_accumulator_next = len_full[ACC_W-1:0];
        if (packet_last) begin
          job_valid  = 1'b1;
          job.kind   = JOB_STATUS;
          job.data   = SC_ZERO;
          job.status = ST_IN_LEN;
        end
      end
    end else begin
      job_valid              = 1'b1;
      payload_remaining_next = rem_dec;
      if (rem_dec == '0) begin
        in_payload_next = 1'b0;
      end
      if (packet_last && rem_dec != '0) begin
        job.status = ST_IN_PAYL;
      end
    end
    if (packet_last) begin
      in_payload_next         = 1'b0;
      length_bytes_seen_next  = '0;
      length_accumulator_next = '0;
      payload_remaining_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_payload         <= 1'b0;
      length_bytes_seen  <= '0;
      length_accumulator <= '0;
      payload_remaining  <= '0;
    end else if (accept) begin
      in_payload         <= in_payload_next;
      length_bytes_seen  <= length_bytes_seen_next;
      length_accumulator <= length_accumulator_next;
      payload_remaining  <= payload_remaining_next;
    end
  end

endmodule

/* rtl/lpn_emit.sv */
// Job register and output register that play each job out as result items.
`timescale 1ns / 1ps

module lpn_emit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           new_valid,
  input  lpn_pkg::job_t                  new_job,
  output logic                           take,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [lpn_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                           m_tuser,
  output logic                           m_tlast
);
  import lpn_pkg::*;

  logic       jvalid;
  job_t       job;
  logic [1:0] cnt;

  logic       out_load;
  logic       piece_last;
  logic [7:0] r_byte;
  logic       r_valid;
  logic       r_run_last;
  logic       r_done;
  status_t    r_status;

  assign out_load   = !m_tvalid || m_tready;
  assign piece_last = (job.kind != JOB_START) || (cnt == SC_LAST);
  assign take       = !jvalid || (out_load && piece_last);

  always_comb begin
    r_byte     = job.data;
    r_valid    = 1'b1;
    r_run_last = 1'b1;
    r_done     = job.done;
    r_status   = job.status;
    case (job.kind)
      JOB_START: begin
        r_byte     = (cnt == SC_LAST) ? SC_ONE : SC_ZERO;
        r_run_last = (cnt == SC_LAST);
        r_done     = job.done && (cnt == SC_LAST);
        r_status   = (cnt == SC_LAST) ? job.status : ST_OK;
      end
      JOB_STATUS: begin
        r_byte  = SC_ZERO;
        r_valid = 1'b0;
      end
      default: begin
        r_byte = job.data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      jvalid   <= 1'b0;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= jvalid;
      end
      if (jvalid && out_load && !piece_last) begin
        cnt <= cnt + 2'd1;
      end
      if (take) begin
        jvalid <= new_valid;
        cnt    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      job <= new_job;
    end
    if (out_load && jvalid) begin
      m_tdata <= {5'd0, r_status, r_run_last, r_byte};
      m_tuser <= r_valid;
      m_tlast <= r_done;
    end
  end

endmodule

/* rtl/length_prefixed_nal_to_start_code_top.sv */
// Top level of the length-prefixed to start-code stream converter.
`timescale 1ns / 1ps

// Converts a length-prefixed video packet, one byte per item, into a
// start-code-delimited stream. Each 4-byte big-endian length becomes the
// start code 00 00 00 01, then the payload bytes pass one per cycle while the
// output is not stalled. A payload byte gives one item; a length byte that
// completes a length gives four items, one per start-code byte, during which
// the input holds off; other length bytes produce nothing, unless they end the
// packet, which gives one status item. Each item passes through the job
// register and the output register. The last item of a packet carries tlast
// and the status: ok, ended inside the length field, or ended inside the
// payload. Bytes already passed on are not withdrawn on error.
module length_prefixed_nal_to_start_code_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,  // [7:0] in_byte
  input  logic                           s_tlast,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [lpn_pkg::OUT_DATA_W-1:0] m_tdata,  // [7:0] out_byte, [8] run_last,
                                                   // [10:9] status, [15:11] zero
  output logic                           m_tuser,  // [0] byte_valid
  output logic                           m_tlast
);
  import lpn_pkg::*;

  logic accept;
  logic job_valid;
  logic take;
  job_t job;

  assign accept = s_tvalid && s_tready;

  lpn_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .in_byte    (s_tdata),
    .packet_last(s_tlast),
    .job_valid  (job_valid),
    .job        (job)
  );

  lpn_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .new_valid(accept && job_valid),
    .new_job  (job),
    .take     (take),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  assign s_tready = take;

endmodule

/* rtl/lpn_checker.sv */
// Port-level checks for the converter top level, bound to it.
`timescale 1ns / 1ps

module lpn_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);
  import lpn_pkg::*;

  a_status_on_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[10:9] != ST_OK) |-> m_tlast)
    else $error("status set on an item that does not end the packet");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[10:9] <= ST_IN_PAYL)
    else $error("undefined status code");

  a_status_only_item: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast && m_tdata[8] && (m_tdata[7:0] == SC_ZERO)
      && (m_tdata[10:9] == ST_IN_LEN))
    else $error("status-only item malformed");

  a_done_ends_run: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[8])
    else $error("packet end not on the last item of a run");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output item changed");

endmodule

bind length_prefixed_nal_to_start_code_top lpn_checker u_lpn_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser),
  .m_tlast (m_tlast)
);
